// ===== design/gedd_pkg.sv =====
// Package for the gamma error-diffusion dither core: types, sizes and the gamma table.
package gedd_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [5:0] red_out;
    logic [5:0] green_out;
    logic [5:0] blue_out;
    logic       frame_end;
  } pix_out_t;

  typedef logic [255:0][7:0] gamma_rom_t;

  // g(i) = round(255 * (i/255)^2.2), ties rounded down, exact integer compare:
  // count of k in 0..254 with 32 * i^11 > (2k+1)^5 * 255^6.
  function automatic gamma_rom_t build_gamma();
    gamma_rom_t  rom;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int unsigned  count;
    for (int unsigned i = 0; i < 256; i++) begin
      lhs = 128'd32;
      for (int unsigned n = 0; n < 11; n++) begin
        lhs = lhs * 128'(i);
      end
      count = 0;
      for (int unsigned k = 0; k < 255; k++) begin
        rhs = 128'd1;
        for (int unsigned n = 0; n < 5; n++) begin
          rhs = rhs * 128'(2 * k + 1);
        end
        for (int unsigned n = 0; n < 6; n++) begin
          rhs = rhs * 128'd255;
        end
        if (lhs > rhs) begin
          count++;
        end
      end
      rom[i] = count[7:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GammaRom = build_gamma();

endpackage

// ===== design/gamma_error_diffusion_dither_core.sv =====
// Gamma error-diffusion dither core: RGB888 in, gamma 2.2, 6-bit dithered RGB out.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o | gedd_pkg::pix_in_t  (RGB888)
//  out     | output    | out_valid_o/out_ready_i | gedd_pkg::pix_out_t (RGB666+eof)
//  cfg     | input     | APB psel/penable      | width @0x0, height @0x4
//
// One beat per clock while in_ready_o is high: gamma lookup, carry add, clamp and
// quantize sit between the input port and the result register, so a pixel shows
// up the cycle after it is taken. The right-neighbour carry is the sole data loop.
// Below-row shares of a 2-bit remainder truncate to zero, so no line buffer is kept.
// Reset clears counters, carry and result valid; size registers reset to 240x240.
// in_ready_o drops only while the result register is full and out_ready_i is low.
module gamma_error_diffusion_dither_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  gedd_pkg::pix_in_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gedd_pkg::pix_out_t                 out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gedd_pkg::ApbAddrW-1:0]      paddr,
  input  logic [gedd_pkg::ApbDataW-1:0]      pwdata,
  output logic [gedd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);

  logic [gedd_pkg::CfgW-1:0] width_q, height_q;
  logic [gedd_pkg::CfgW-1:0] w_eff, h_eff;
  logic [gedd_pkg::ColW-1:0] col_q, col_d, x;
  logic [gedd_pkg::RowW-1:0] row_q, row_d, y;
  logic [2:0]                carry_q, carry_d, carry_use;
  logic                      out_valid_q;
  gedd_pkg::pix_out_t        out_q, out_d;
  logic                      in_fire, cfg_wr, has_right, has_below;
  logic [7:0]                chan_in [3];
  logic [5:0]                chan_out [3];
  gedd_pkg::cfg_reg_e        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = gedd_pkg::cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      gedd_pkg::REG_IMAGE_WIDTH:  prdata = gedd_pkg::ApbDataW'(width_q);
      gedd_pkg::REG_IMAGE_HEIGHT: prdata = gedd_pkg::ApbDataW'(height_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gedd_pkg::CfgW'(240);
      height_q <= gedd_pkg::CfgW'(240);
    end else if (cfg_wr) begin
      case (reg_sel)
        gedd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[gedd_pkg::CfgW-1:0];
        gedd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[gedd_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and clamped position
  always_comb begin
    if (width_q == '0) begin
      w_eff = gedd_pkg::CfgW'(1);
    end else if (width_q > gedd_pkg::CfgW'(gedd_pkg::MaxWidth)) begin
      w_eff = gedd_pkg::CfgW'(gedd_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = gedd_pkg::CfgW'(1);
    end else if (height_q > gedd_pkg::CfgW'(gedd_pkg::MaxHeight)) begin
      h_eff = gedd_pkg::CfgW'(gedd_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign x = (gedd_pkg::CfgW'(col_q) < w_eff) ? col_q
           : gedd_pkg::ColW'(w_eff - gedd_pkg::CfgW'(1));
  assign y = (gedd_pkg::CfgW'(row_q) < h_eff) ? row_q
           : gedd_pkg::RowW'(h_eff - gedd_pkg::CfgW'(1));
  assign has_right = (gedd_pkg::CfgW'(x) + gedd_pkg::CfgW'(1)) < w_eff;
  assign has_below = (gedd_pkg::CfgW'(y) + gedd_pkg::CfgW'(1)) < h_eff;
  assign carry_use = (x == '0) ? 3'b000 : carry_q;

  assign chan_in[0] = in_data_i.red_in;
  assign chan_in[1] = in_data_i.green_in;
  assign chan_in[2] = in_data_i.blue_in;

  // Per channel: gamma, add carry, clamp, split into output and remainder
  always_comb begin
    logic [8:0] sum;
    logic [7:0] sat;
    for (int ch = 0; ch < 3; ch++) begin
      sum = {1'b0, gedd_pkg::GammaRom[chan_in[ch]]} + {8'd0, carry_use[ch]};
      sat = sum[8] ? 8'hFF : sum[7:0];
      chan_out[ch] = sat[7:2];
      carry_d[ch]  = has_right && (sat[1:0] == 2'b11);
    end
  end

  always_comb begin
    out_d.red_out   = chan_out[0];
    out_d.green_out = chan_out[1];
    out_d.blue_out  = chan_out[2];
    out_d.frame_end = !has_right && !has_below;
    if (has_right) begin
      col_d = x + gedd_pkg::ColW'(1);
      row_d = y;
    end else begin
      col_d = '0;
      row_d = has_below ? y + gedd_pkg::RowW'(1) : '0;
    end
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q   <= col_d;
        row_q   <= row_d;
        carry_q <= carry_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_eof_wraps_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_end) |-> (col_q == '0 && row_q == '0))
    else $error("frame end without position wrap");

  a_row_end_drops_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !has_right) |=> (carry_q == '0))
    else $error("carry kept across row end");

endmodule
